// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the hpack parser rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HFRP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hfrp assertion failed");

// consequent must hold in the cycle after the antecedent
`define HFRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hfrp assertion failed");

`endif

// ===== rtl/core/hfrp_pkg.sv =====
// shared types and codes for the hpack field representation parser
// no dependencies; imported by hfrp_parse and the top level module
`default_nettype none

package hfrp_pkg;

	// result event codes
	localparam logic [1:0] EV_INT   = 2'd0;
	localparam logic [1:0] EV_STR   = 2'd1;
	localparam logic [1:0] EV_EMPTY = 2'd2;
	localparam logic [1:0] EV_ERR   = 2'd3;

	// representation kinds
	localparam logic [2:0] KIND_INDEXED = 3'd0;
	localparam logic [2:0] KIND_INCR    = 3'd1;
	localparam logic [2:0] KIND_SIZE    = 3'd2;
	localparam logic [2:0] KIND_NOIDX   = 3'd3;
	localparam logic [2:0] KIND_NEVER   = 3'd4;

	// prefix masks of the first byte and of the string length
	localparam logic [6:0] MASK_7 = 7'h7F;
	localparam logic [6:0] MASK_6 = 7'h3F;
	localparam logic [6:0] MASK_5 = 7'h1F;
	localparam logic [6:0] MASK_4 = 7'h0F;

	// continuation shift handling
	localparam logic [5:0] SHIFT_STEP  = 6'd7;
	localparam logic [4:0] SHIFT_SAT   = 5'd31;
	localparam logic [4:0] SHIFT_LIMIT = 5'd28;

	// everything of a result word except the integer value
	typedef struct packed {
		logic [1:0] event_res;
		logic [2:0] repr_kind;
		logic [7:0] data_byte;
		logic       in_value;
		logic       huffman;
		logic       field_done;
	} res_meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/hfrp_if.sv =====
// valid/ready channel interfaces for header bytes and parse results
// depends on nothing; used by the top level ports
`default_nettype none

interface hfrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       block_end;

	modport source (output valid, output in_byte, output block_end, input ready);
	modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

interface hfrp_res_if #(
	parameter int INT_BITS = 28
);
	logic                valid;
	logic                ready;
	logic [1:0]          event_res;
	logic [2:0]          repr_kind;
	logic [INT_BITS-1:0] int_value;
	logic [7:0]          data_byte;
	logic                in_value;
	logic                huffman;
	logic                field_done;

	modport source (output valid, output event_res, output repr_kind, output int_value,
		output data_byte, output in_value, output huffman, output field_done,
		input ready);
	modport sink   (input valid, input event_res, input repr_kind, input int_value,
		input data_byte, input in_value, input huffman, input field_done,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hfrp_parse.sv =====
// parse state machine: one header byte per step, at most one result word
// depends on hfrp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hfrp_parse import hfrp_pkg::*; #(
	parameter int INT_BITS = 28
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          hdr_byte,
	input  wire logic                blk_end,
	output logic                     res_valid,
	output res_meta_t                res_meta,
	output logic [INT_BITS-1:0]      res_int
);

	localparam logic [2:0] PH_FIRST     = 3'd0;
	localparam logic [2:0] PH_IDX_CONT  = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_CONT  = 3'd3;
	localparam logic [2:0] PH_DATA      = 3'd4;
	localparam logic [2:0] PH_DRAIN     = 3'd5;

	localparam int SUM_W = INT_BITS + 39 - INT_BITS + 1;

	logic [2:0]          phase_q, phase_n;
	logic [INT_BITS-1:0] acc_q, acc_n;
	logic [4:0]          shift_q, shift_n;
	logic [INT_BITS-1:0] left_q, left_n;
	logic [2:0]          kind_q, kind_n;
	logic                huff_q, huff_n;
	logic                inval_q, inval_n;

	// continuation byte arithmetic
	logic [6:0]          chunk;
	logic [SUM_W-1:0]    cont_sum;
	logic                cont_ovf;
	logic [5:0]          shift_inc;
	logic [4:0]          shift_adv;

	logic [6:0]          mask;
	logic                idx_done, len_done, str_done, err, draining, last;
	logic [INT_BITS-1:0] idx_val, len_val;

	assign chunk     = hdr_byte[6:0];
	assign cont_sum  = SUM_W'(acc_q) + (SUM_W'(chunk) << shift_q);
	assign cont_ovf  = (chunk != 7'd0) &&
		(({1'b0, shift_q} >= 6'(INT_BITS)) || (shift_q > SHIFT_LIMIT) ||
		(cont_sum[SUM_W-1:INT_BITS] != '0));
	assign shift_inc = {1'b0, shift_q} + SHIFT_STEP;
	assign shift_adv = (shift_inc > {1'b0, SHIFT_SAT}) ? SHIFT_SAT : shift_inc[4:0];
	assign last      = (left_q <= INT_BITS'(1));

	// next state and result for the byte at hand
	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		shift_n   = shift_q;
		left_n    = left_q;
		kind_n    = kind_q;
		huff_n    = huff_q;
		inval_n   = inval_q;
		res_valid = 1'b0;
		res_meta  = '0;
		res_int   = '0;
		mask      = MASK_7;
		idx_done  = 1'b0;
		len_done  = 1'b0;
		str_done  = 1'b0;
		err       = 1'b0;
		draining  = 1'b0;
		idx_val   = '0;
		len_val   = '0;

		unique case (phase_q)
			PH_FIRST: begin
				if (hdr_byte[7]) begin
					kind_n = KIND_INDEXED;
					mask   = MASK_7;
				end else if (hdr_byte[6]) begin
					kind_n = KIND_INCR;
					mask   = MASK_6;
				end else if (hdr_byte[5]) begin
					kind_n = KIND_SIZE;
					mask   = MASK_5;
				end else if (hdr_byte[4]) begin
					kind_n = KIND_NEVER;
					mask   = MASK_4;
				end else begin
					kind_n = KIND_NOIDX;
					mask   = MASK_4;
				end
				huff_n  = 1'b0;
				inval_n = 1'b0;
				if ((chunk & mask) != mask) begin
					idx_done = 1'b1;
					idx_val  = INT_BITS'(chunk & mask);
				end else begin
					acc_n   = INT_BITS'(mask);
					shift_n = '0;
					phase_n = PH_IDX_CONT;
				end
			end
			PH_IDX_CONT, PH_LEN_CONT: begin
				if (cont_ovf) begin
					err = 1'b1;
				end else begin
					if (chunk != 7'd0) acc_n = cont_sum[INT_BITS-1:0];
					if (hdr_byte[7]) begin
						shift_n = shift_adv;
					end else if (phase_q == PH_IDX_CONT) begin
						idx_done = 1'b1;
						idx_val  = acc_n;
					end else begin
						len_done = 1'b1;
						len_val  = acc_n;
					end
				end
			end
			PH_LEN_FIRST: begin
				huff_n = hdr_byte[7];
				if (chunk != MASK_7) begin
					len_done = 1'b1;
					len_val  = INT_BITS'(chunk);
				end else begin
					acc_n   = INT_BITS'(MASK_7);
					shift_n = '0;
					phase_n = PH_LEN_CONT;
				end
			end
			PH_DATA: begin
				res_valid           = 1'b1;
				res_meta.event_res  = EV_STR;
				res_meta.repr_kind  = kind_q;
				res_meta.data_byte  = hdr_byte;
				res_meta.in_value   = inval_q;
				res_meta.huffman    = huff_q;
				res_meta.field_done = last && inval_q;
				left_n   = last ? '0 : left_q - INT_BITS'(1);
				str_done = last;
			end
			PH_DRAIN: begin
				draining = 1'b1;
				if (blk_end) phase_n = PH_FIRST;
			end
			default: begin
				phase_n = PH_FIRST;
			end
		endcase

		// integer of the first byte finished
		if (idx_done) begin
			res_valid          = 1'b1;
			res_meta.event_res = EV_INT;
			res_meta.repr_kind = kind_n;
			res_int            = idx_val;
			if (kind_n == KIND_INDEXED || kind_n == KIND_SIZE) begin
				res_meta.field_done = 1'b1;
				phase_n             = PH_FIRST;
			end else begin
				inval_n = (idx_val != '0);
				phase_n = PH_LEN_FIRST;
			end
		end

		// string length finished
		if (len_done) begin
			if (len_val == '0) begin
				res_valid           = 1'b1;
				res_meta.event_res  = EV_EMPTY;
				res_meta.repr_kind  = kind_n;
				res_meta.in_value   = inval_n;
				res_meta.huffman    = huff_n;
				res_meta.field_done = inval_n;
				str_done            = 1'b1;
			end else begin
				left_n  = len_val;
				phase_n = PH_DATA;
			end
		end

		// name string is followed by the value string
		if (str_done) begin
			if (inval_n) begin
				phase_n = PH_FIRST;
			end else begin
				inval_n = 1'b1;
				phase_n = PH_LEN_FIRST;
			end
		end

		// overflow or block cut short mid-field
		if (err || (!draining && blk_end && phase_n != PH_FIRST)) begin
			res_valid          = 1'b1;
			res_meta           = '0;
			res_meta.event_res = EV_ERR;
			res_meta.repr_kind = kind_n;
			res_int            = '0;
			phase_n            = (err && !blk_end) ? PH_DRAIN : PH_FIRST;
		end

		if (!step) res_valid = 1'b0;
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			acc_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			kind_q  <= KIND_INDEXED;
			huff_q  <= 1'b0;
			inval_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			shift_q <= shift_n;
			left_q  <= left_n;
			kind_q  <= kind_n;
			huff_q  <= huff_n;
			inval_q <= inval_n;
		end
	end

	`HFRP_ASSERT_NEXT(a_end_restarts, clk, arst_n, step && blk_end, phase_q == PH_FIRST)
	`HFRP_ASSERT_NEXT(a_err_leaves_field, clk, arst_n,
		res_valid && res_meta.event_res == EV_ERR,
		phase_q == PH_FIRST || phase_q == PH_DRAIN)
	`HFRP_ASSERT(a_data_has_bytes, clk, arst_n, phase_q != PH_DATA || left_q != '0)

endmodule

`default_nettype wire

// ===== rtl/core/hfrp_obuf.sv =====
// two-entry result buffer that decouples the parser from the result channel
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hfrp_obuf #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              room,
	output logic              valid,
	input  wire logic         ready,
	output logic [W-1:0]      dout
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign room  = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && ready;
	assign dout  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`HFRP_ASSERT(a_no_push_when_full, clk, arst_n, !push || cnt_q != 2'd2)

endmodule

`default_nettype wire

// ===== rtl/core/hpack_field_representation_parser.sv =====
// HPACK field representation parser, one header byte per cycle.
// A result word shows on res once the input stage has loaded its byte at acceptance
// and the parse step has written the word into the result buffer. Throughput: 1
// byte per cycle; bytes yielding no result still take one step; a full result
// buffer holds the input.
// Reset (arst_n low) returns to awaiting a first byte and empties both stages.
`default_nettype none

module hpack_field_representation_parser import hfrp_pkg::*; #(
	parameter int INT_BITS = 28
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hfrp_byte_if.sink  hdr,
	hfrp_res_if.source res
);

	localparam int RES_W = $bits(res_meta_t) + INT_BITS;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                room;
	logic                step;
	logic                res_valid;
	res_meta_t           res_meta;
	logic [INT_BITS-1:0] res_int;
	logic [RES_W-1:0]    buf_dout;
	res_meta_t           out_meta;

	assign step      = valid_s1 && room;
	assign hdr.ready = !valid_s1 || room;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			byte_s1 <= hdr.in_byte;
			end_s1  <= hdr.block_end;
		end
	end

	hfrp_parse #(
		.INT_BITS (INT_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.hdr_byte  (byte_s1),
		.blk_end   (end_s1),
		.res_valid (res_valid),
		.res_meta  (res_meta),
		.res_int   (res_int)
	);

	hfrp_obuf #(
		.W (RES_W)
	) u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    ({res_meta, res_int}),
		.room   (room),
		.valid  (res.valid),
		.ready  (res.ready),
		.dout   (buf_dout)
	);

	// unpack the result word onto the channel
	assign out_meta       = buf_dout[RES_W-1:INT_BITS];
	assign res.int_value  = buf_dout[INT_BITS-1:0];
	assign res.event_res  = out_meta.event_res;
	assign res.repr_kind  = out_meta.repr_kind;
	assign res.data_byte  = out_meta.data_byte;
	assign res.in_value   = out_meta.in_value;
	assign res.huffman    = out_meta.huffman;
	assign res.field_done = out_meta.field_done;

endmodule

`default_nettype wire
